/* sv/amgdiw_pkg.sv */
// shared types and constants for the amg direct interpolation weight block
// no dependencies
`default_nettype none

package amgdiw_pkg;

   // width of entry, weight and factor values (signed q16.16)
   localparam int VALUE_BITS = 32;
   // fraction bits of a value
   localparam int FRAC_BITS  = 16;
   // scaling of a quotient numerator (twice the fraction bits)
   localparam int FRAC2_BITS = 32;

   // request commands
   localparam logic CMD_ENTRY  = 1'b0;
   localparam logic CMD_WEIGHT = 1'b1;

   // result kinds
   localparam logic KIND_FACTORS = 1'b0;
   localparam logic KIND_WEIGHT  = 1'b1;

   typedef struct packed {
      logic                         command;
      logic signed [VALUE_BITS-1:0] value;
      logic                         on_diagonal;
      logic                         neighbour_is_coarse;
      logic                         row_end;
   } req_type;

   typedef struct packed {
      logic                         result_kind;
      logic signed [VALUE_BITS-1:0] alpha_factor;
      logic signed [VALUE_BITS-1:0] beta_factor;
      logic signed [VALUE_BITS-1:0] scaled_weight;
      logic                         diagonal_missing;
   } rsp_type;

endpackage

`default_nettype wire

/* sv/amgdiw_mul.sv */
// radix-2 shift-add multiplier, one multiplier bit per cycle
// standalone, no package use
`default_nettype none

module amgdiw_mul #(
   parameter int A_BITS = 48,
   parameter int B_BITS = 32
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   input  wire logic [A_BITS-1:0]        a,
   input  wire logic [B_BITS-1:0]        b,
   output logic                          done,
   output logic [A_BITS+B_BITS-1:0]      product
);

   localparam int CNT_BITS = (B_BITS > 1) ? $clog2(B_BITS) : 1;
   localparam logic [CNT_BITS-1:0] LAST = CNT_BITS'(B_BITS - 1);

   logic [A_BITS-1:0]   mcand_ff, mcand_in;
   logic [A_BITS-1:0]   acc_ff, acc_in;
   logic [B_BITS-1:0]   mplr_ff, mplr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [A_BITS:0]     sum;

   always_comb begin
      mcand_in = mcand_ff;
      acc_in   = acc_ff;
      mplr_in  = mplr_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      sum      = {1'b0, acc_ff} + (mplr_ff[0] ? {1'b0, mcand_ff} : '0);
      if (start) begin
         mcand_in = a;
         mplr_in  = b;
         acc_in   = '0;
         count_in = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         acc_in   = sum[A_BITS:1];
         mplr_in  = {sum[0], mplr_ff[B_BITS-1:1]};
         count_in = count_ff + 1'b1;
         if (count_ff == LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      mcand_ff <= mcand_in;
      acc_ff   <= acc_in;
      mplr_ff  <= mplr_in;
   end

   assign done    = done_ff;
   assign product = {acc_ff, mplr_ff};

endmodule

`default_nettype wire

/* sv/amgdiw_div.sv */
// restoring divider, one quotient bit per cycle, saturation flag for wide quotients
// standalone, no package use
`default_nettype none

module amgdiw_div #(
   parameter int N_BITS = 80,
   parameter int D_BITS = 80,
   parameter int Q_BITS = 31
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [N_BITS-1:0] num,
   input  wire logic [D_BITS-1:0] den,
   output logic                   done,
   output logic [Q_BITS-1:0]      quotient,
   output logic                   overflow
);

   localparam int CNT_BITS = $clog2(N_BITS);
   localparam logic [CNT_BITS-1:0] LAST = CNT_BITS'(N_BITS - 1);

   logic [N_BITS-1:0]   num_ff, num_in;
   logic [D_BITS-1:0]   den_ff, den_in;
   logic [D_BITS-1:0]   rem_ff, rem_in;
   logic [Q_BITS-1:0]   quo_ff, quo_in;
   logic                ovf_ff, ovf_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [D_BITS:0]     rem_sh;
   logic [D_BITS:0]     diff;
   logic                ge;

   always_comb begin
      num_in   = num_ff;
      den_in   = den_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      ovf_in   = ovf_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      rem_sh   = {rem_ff, num_ff[N_BITS-1]};
      ge       = rem_sh >= {1'b0, den_ff};
      diff     = rem_sh - {1'b0, den_ff};
      if (start) begin
         num_in   = num;
         den_in   = den;
         rem_in   = '0;
         quo_in   = '0;
         ovf_in   = 1'b0;
         count_in = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         num_in   = {num_ff[N_BITS-2:0], 1'b0};
         rem_in   = ge ? diff[D_BITS-1:0] : rem_sh[D_BITS-1:0];
         // any bit pushed out of the kept quotient means the value is too big
         ovf_in   = ovf_ff | quo_ff[Q_BITS-1];
         quo_in   = {quo_ff[Q_BITS-2:0], ge};
         count_in = count_ff + 1'b1;
         if (count_ff == LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      ovf_ff <= ovf_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
   assign overflow = ovf_ff;

endmodule

`default_nettype wire

/* sv/amg_direct_interpolation_weights.sv */
// direct interpolation weight factors for one fine row, top level
// depends on amgdiw_pkg, amgdiw_mul and amgdiw_div
`default_nettype none

// The block takes the nonzeros of one fine matrix row as requests of command
// entry, then scales interpolation weights as requests of command weight.
// Off-diagonal entries go into saturating negative and positive sums (all
// neighbours and coarse neighbours only); the diagonal is latched. The request
// that carries row_end yields one response with alpha and beta, each the total
// sum over (coarse sum times diagonal) in q16.16, or the raw total when the
// coarse sum is zero; a zero diagonal saturates the factor. A weight request
// yields one response with the weight times minus alpha (negative weight) or
// minus beta (positive weight). An entry without row_end leaves the block idle, so
// a new request can be taken in the next cycle; other requests stall until the
// block is idle again. A nonzero weight runs the bit-serial multiplier. A row end
// runs each factor through the serial multiplier for coarse sum times diagonal,
// then the restoring divider over SUM_BITS + 32 numerator bits, and both factors
// share the two units. A factor with a zero coarse sum, zero total or zero
// diagonal skips both units. The response register lets the next request in
// while a response still waits.

module amg_direct_interpolation_weights #(
   parameter int SUM_BITS = 48
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire amgdiw_pkg::req_type req_payload,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output amgdiw_pkg::rsp_type      rsp_payload
);

   import amgdiw_pkg::*;

   // magnitude width shared by sums and values
   localparam int MW = (SUM_BITS > VALUE_BITS) ? SUM_BITS : VALUE_BITS;
   // multiplier product width
   localparam int PW = MW + VALUE_BITS;
   // divider numerator width: |sum| scaled by two fraction widths
   localparam int NW = SUM_BITS + FRAC2_BITS;
   // signed working width for clamps
   localparam int EW = MW + 2;

   localparam logic [VALUE_BITS-1:0] VMAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
   localparam logic [VALUE_BITS-1:0] VMIN = {1'b1, {(VALUE_BITS-1){1'b0}}};
   localparam logic signed [EW-1:0] SUM_HI =
      {{(EW-SUM_BITS+1){1'b0}}, {(SUM_BITS-1){1'b1}}};
   localparam logic signed [EW-1:0] SUM_LO =
      {{(EW-SUM_BITS+1){1'b1}}, {(SUM_BITS-1){1'b0}}};
   localparam logic signed [EW-1:0] VAL_HI =
      {{(EW-VALUE_BITS+1){1'b0}}, {(VALUE_BITS-1){1'b1}}};
   localparam logic signed [EW-1:0] VAL_LO =
      {{(EW-VALUE_BITS+1){1'b1}}, {(VALUE_BITS-1){1'b0}}};

   typedef enum logic [2:0] {
      S_IDLE,
      S_FSETUP,
      S_FMUL,
      S_FDIV,
      S_WMUL,
      S_OUT
   } state_type;

   // magnitude of a value, fits unsigned in the same width
   function automatic logic [VALUE_BITS-1:0] mag_v(input logic [VALUE_BITS-1:0] x);
      return x[VALUE_BITS-1] ? (~x + 1'b1) : x;
   endfunction

   function automatic logic [SUM_BITS-1:0] mag_s(input logic [SUM_BITS-1:0] x);
      return x[SUM_BITS-1] ? (~x + 1'b1) : x;
   endfunction

   // sum plus entry, clamped to the sum range
   function automatic logic [SUM_BITS-1:0] sat_add(input logic [SUM_BITS-1:0] s,
                                                   input logic [VALUE_BITS-1:0] v);
      logic signed [EW-1:0] t;
      t = $signed({{(EW-SUM_BITS){s[SUM_BITS-1]}}, s})
        + $signed({{(EW-VALUE_BITS){v[VALUE_BITS-1]}}, v});
      if (t > SUM_HI) begin
         return SUM_HI[SUM_BITS-1:0];
      end
      if (t < SUM_LO) begin
         return SUM_LO[SUM_BITS-1:0];
      end
      return t[SUM_BITS-1:0];
   endfunction

   // raw total clamped to the value range
   function automatic logic [VALUE_BITS-1:0] sat_val(input logic [SUM_BITS-1:0] s);
      logic signed [EW-1:0] t;
      t = $signed({{(EW-SUM_BITS){s[SUM_BITS-1]}}, s});
      if (t > VAL_HI) begin
         return VMAX;
      end
      if (t < VAL_LO) begin
         return VMIN;
      end
      return t[VALUE_BITS-1:0];
   endfunction

   // state and registered outputs
   state_type             state_ff, state_in;
   logic [SUM_BITS-1:0]   nsum_ff, nsum_in;
   logic [SUM_BITS-1:0]   psum_ff, psum_in;
   logic [SUM_BITS-1:0]   ncsum_ff, ncsum_in;
   logic [SUM_BITS-1:0]   pcsum_ff, pcsum_in;
   logic [VALUE_BITS-1:0] diag_ff, diag_in;
   logic                  seen_ff, seen_in;
   logic [VALUE_BITS-1:0] alpha_ff, alpha_in;
   logic [VALUE_BITS-1:0] beta_ff, beta_in;
   logic                  missing_ff, missing_in;
   logic                  sel_ff, sel_in;      // 0 while forming alpha, 1 for beta
   logic                  fneg_ff, fneg_in;    // sign of the result being formed
   logic                  kind_ff, kind_in;
   logic [VALUE_BITS-1:0] res_ff, res_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   // shared arithmetic units
   logic                  mul_start;
   logic [MW-1:0]         mul_a;
   logic [VALUE_BITS-1:0] mul_b;
   logic                  mul_done;
   logic [PW-1:0]         mul_prod;
   logic                  div_start;
   logic                  div_done;
   logic [VALUE_BITS-2:0] div_q;
   logic                  div_ovf;

   // per-request and per-factor helpers
   logic                  req_take;
   logic [VALUE_BITS-1:0] req_v;
   logic                  w_neg;
   logic [VALUE_BITS-1:0] w_factor;
   logic [SUM_BITS-1:0]   s_sel;
   logic [SUM_BITS-1:0]   c_sel;
   logic                  fac_ready;
   logic [VALUE_BITS-1:0] fac_val;
   logic                  prod_ovf;
   logic [VALUE_BITS-2:0] prod_q;
   logic [VALUE_BITS-1:0] div_val;
   logic [VALUE_BITS-1:0] scale_val;

   assign req_take = req_valid && !req_stall;
   assign req_v    = req_payload.value;
   assign w_neg    = req_v[VALUE_BITS-1];
   assign w_factor = w_neg ? alpha_ff : beta_ff;
   assign s_sel    = sel_ff ? psum_ff : nsum_ff;
   assign c_sel    = sel_ff ? pcsum_ff : ncsum_ff;

   // quotient with sign, saturated
   assign div_val = div_ovf ? (fneg_ff ? VMIN : VMAX)
                  : (fneg_ff ? (~{1'b0, div_q} + 1'b1) : {1'b0, div_q});

   // weight product drops the fraction bits, anything above the value range saturates
   assign prod_ovf  = |mul_prod[PW-1:FRAC_BITS+VALUE_BITS-1];
   assign prod_q    = mul_prod[FRAC_BITS+VALUE_BITS-2:FRAC_BITS];
   assign scale_val = prod_ovf ? (fneg_ff ? VMIN : VMAX)
                    : (fneg_ff ? (~{1'b0, prod_q} + 1'b1) : {1'b0, prod_q});

   amgdiw_mul #(
      .A_BITS (MW),
      .B_BITS (VALUE_BITS)
   ) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (mul_a),
      .b       (mul_b),
      .done    (mul_done),
      .product (mul_prod)
   );

   amgdiw_div #(
      .N_BITS (NW),
      .D_BITS (PW),
      .Q_BITS (VALUE_BITS-1)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .num      ({mag_s(s_sel), {FRAC2_BITS{1'b0}}}),
      .den      (mul_prod),
      .done     (div_done),
      .quotient (div_q),
      .overflow (div_ovf)
   );

   always_comb begin
      state_in     = state_ff;
      nsum_in      = nsum_ff;
      psum_in      = psum_ff;
      ncsum_in     = ncsum_ff;
      pcsum_in     = pcsum_ff;
      diag_in      = diag_ff;
      seen_in      = seen_ff;
      alpha_in     = alpha_ff;
      beta_in      = beta_ff;
      missing_in   = missing_ff;
      sel_in       = sel_ff;
      fneg_in      = fneg_ff;
      kind_in      = kind_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      mul_start    = 1'b0;
      mul_a        = '0;
      mul_b        = '0;
      div_start    = 1'b0;
      fac_ready    = 1'b0;
      fac_val      = '0;

      // response taken downstream
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               if (req_payload.command == CMD_WEIGHT) begin
                  kind_in = KIND_WEIGHT;
                  if (req_v == '0) begin
                     res_in   = '0;
                     state_in = S_OUT;
                  end else begin
                     // -f*w is negative when f and w share a sign
                     mul_start = 1'b1;
                     mul_a     = MW'(mag_v(w_factor));
                     mul_b     = mag_v(req_v);
                     fneg_in   = (w_factor[VALUE_BITS-1] == w_neg);
                     state_in  = S_WMUL;
                  end
               end else begin
                  if (req_payload.on_diagonal) begin
                     diag_in = req_v;
                     seen_in = 1'b1;
                  end else if (w_neg) begin
                     nsum_in = sat_add(nsum_ff, req_v);
                     if (req_payload.neighbour_is_coarse) begin
                        ncsum_in = sat_add(ncsum_ff, req_v);
                     end
                  end else if (req_v != '0) begin
                     psum_in = sat_add(psum_ff, req_v);
                     if (req_payload.neighbour_is_coarse) begin
                        pcsum_in = sat_add(pcsum_ff, req_v);
                     end
                  end
                  if (req_payload.row_end) begin
                     missing_in = !(seen_ff || req_payload.on_diagonal);
                     kind_in    = KIND_FACTORS;
                     sel_in     = 1'b0;
                     state_in   = S_FSETUP;
                  end
               end
            end
         end
         S_FSETUP: begin
            if (c_sel == '0) begin
               // no coarse connection: raw total
               fac_ready = 1'b1;
               fac_val   = sat_val(s_sel);
            end else if (s_sel == '0) begin
               fac_ready = 1'b1;
               fac_val   = '0;
            end else if (diag_ff == '0) begin
               // zero divisor saturates by the sign of sum times coarse sum
               fac_ready = 1'b1;
               fac_val   = (s_sel[SUM_BITS-1] ^ c_sel[SUM_BITS-1]) ? VMIN : VMAX;
            end else begin
               mul_start = 1'b1;
               mul_a     = MW'(mag_s(c_sel));
               mul_b     = mag_v(diag_ff);
               fneg_in   = s_sel[SUM_BITS-1] ^ c_sel[SUM_BITS-1] ^ diag_ff[VALUE_BITS-1];
               state_in  = S_FMUL;
            end
         end
         S_FMUL: begin
            if (mul_done) begin
               div_start = 1'b1;
               state_in  = S_FDIV;
            end
         end
         S_FDIV: begin
            if (div_done) begin
               fac_ready = 1'b1;
               fac_val   = div_val;
            end
         end
         S_WMUL: begin
            if (mul_done) begin
               res_in   = scale_val;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in            = 1'b1;
               rsp_in.result_kind      = kind_ff;
               rsp_in.alpha_factor     = alpha_ff;
               rsp_in.beta_factor      = beta_ff;
               rsp_in.scaled_weight    = (kind_ff == KIND_WEIGHT) ? res_ff : '0;
               rsp_in.diagonal_missing = (kind_ff == KIND_FACTORS) ? missing_ff : 1'b0;
               state_in                = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // a finished factor: alpha moves on to beta, beta closes the row
      if (fac_ready) begin
         if (!sel_ff) begin
            alpha_in = fac_val;
            sel_in   = 1'b1;
            state_in = S_FSETUP;
         end else begin
            beta_in  = fac_val;
            nsum_in  = '0;
            psum_in  = '0;
            ncsum_in = '0;
            pcsum_in = '0;
            seen_in  = 1'b0;
            state_in = S_OUT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         nsum_ff      <= '0;
         psum_ff      <= '0;
         ncsum_ff     <= '0;
         pcsum_ff     <= '0;
         diag_ff      <= '0;
         seen_ff      <= 1'b0;
         alpha_ff     <= '0;
         beta_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         nsum_ff      <= nsum_in;
         psum_ff      <= psum_in;
         ncsum_ff     <= ncsum_in;
         pcsum_ff     <= pcsum_in;
         diag_ff      <= diag_in;
         seen_ff      <= seen_in;
         alpha_ff     <= alpha_in;
         beta_ff      <= beta_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      missing_ff <= missing_in;
      sel_ff     <= sel_in;
      fneg_ff    <= fneg_in;
      kind_ff    <= kind_in;
      res_ff     <= res_in;
      rsp_ff     <= rsp_in;
   end

   assign req_stall   = (state_ff != S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // multiplier results only land while a multiply is awaited
   a_mul_done_state: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> (state_ff == S_FMUL || state_ff == S_WMUL))
      else $error("multiplier finished outside a multiply wait");

   // divider results only land while a division is awaited
   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_FDIV))
      else $error("divider finished outside a divide wait");

   // an entry without row end leaves the block idle in the next cycle
   a_entry_single: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_payload.command == CMD_ENTRY && !req_payload.row_end)
      |=> (state_ff == S_IDLE))
      else $error("plain entry did not return to idle");

   // the row's sums and diagonal flag are clear once its factors are out
   a_row_cleared: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && kind_ff == KIND_FACTORS)
      |-> (nsum_ff == '0 && psum_ff == '0 && ncsum_ff == '0 && pcsum_ff == '0
           && !seen_ff))
      else $error("row state not cleared at row end");

endmodule

`default_nettype wire
